// ===== design/mbrtu_pkg.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU response receiver package
// Shared types, constants and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int unsigned MaxFrame = 1024;
  localparam int unsigned CntW     = $clog2(MaxFrame) + 1;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned StatW    = 3;

  localparam logic [CntW-1:0] FrameLenShort = CntW'(8);
  localparam logic [CntW-1:0] FrameLenMulti = CntW'(9);
  localparam logic [CntW-1:0] ReadHdrLen    = CntW'(5);
  localparam logic [CntW-1:0] ReadExtLen    = CntW'(256);
  localparam logic [15:0]     QtyExtLimit   = 16'd128;
  localparam logic [15:0]     CrcInit       = 16'hFFFF;
  localparam logic [15:0]     CrcPoly       = 16'hA001;
  localparam logic [7:0]      BcastAddr     = 8'd0;
  localparam logic [IdxW-1:0] IdxMax        = '1;

  localparam logic [7:0] FcReadCoils   = 8'd1;
  localparam logic [7:0] FcReadHold    = 8'd3;
  localparam logic [7:0] FcReadInput   = 8'd4;
  localparam logic [7:0] FcWriteCoil   = 8'd5;
  localparam logic [7:0] FcWriteReg    = 8'd6;
  localparam logic [7:0] FcWriteCoils  = 8'd15;
  localparam logic [7:0] FcWriteRegs   = 8'd16;

  typedef enum logic [0:0] {
    CFG_DEV_ADDR = 1'b0,
    CFG_REQ_QTY  = 1'b1
  } cfg_idx_e;

  typedef enum logic [StatW-1:0] {
    ST_RECV      = 3'd0,
    ST_GOOD      = 3'd1,
    ST_BAD_ADDR  = 3'd2,
    ST_BAD_FUNC  = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_CRC_ERR   = 3'd5
  } status_e;

  typedef struct packed {
    status_e         status;
    logic [IdxW-1:0] byte_index;
    logic [7:0]      data_byte;
  } result_t;

  function automatic logic [15:0] crc_upd(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic code_ok(logic [7:0] fc);
    return fc == FcReadCoils || fc == FcReadHold || fc == FcReadInput ||
           fc == FcWriteCoil || fc == FcWriteReg || fc == FcWriteCoils ||
           fc == FcWriteRegs;
  endfunction

endpackage

// ===== design/mbrtu_core.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU frame tracker
// Holds the frame state, checks address, function and length, runs the CRC.
// ----------------------------------------------------------------------------
module mbrtu_core import mbrtu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [7:0]  dev_addr_i,
  input  logic [15:0] req_qty_i,
  output result_t     res_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      fc_q, fc_d;
  logic [7:0]      len_q, len_d;
  logic [15:0]     crc_q, crc_d;

  logic [CntW-1:0] cnt_inc, target;
  logic [15:0]     crc_n;
  logic            ovf, done;

  assign ovf     = cnt_q >= CntW'(MaxFrame);
  assign cnt_inc = cnt_q + CntW'(1);
  assign crc_n   = crc_upd(crc_q, byte_i);

  always_comb begin
    fc_d  = fc_q;
    len_d = len_q;
    if (cnt_q == CntW'(1)) begin
      fc_d = byte_i;
    end
    if (cnt_q == CntW'(2)) begin
      len_d = byte_i;
    end
  end

  always_comb begin
    target = ReadHdrLen + {{(CntW-8){1'b0}}, len_d};
    if (req_qty_i > QtyExtLimit) begin
      target = target + ReadExtLen;
    end
    unique case (fc_d)
      FcWriteCoil, FcWriteReg, FcWriteRegs: done = cnt_inc == FrameLenShort;
      FcWriteCoils:                          done = cnt_inc == FrameLenMulti;
      FcReadCoils, FcReadHold, FcReadInput:  done = cnt_inc >= CntW'(3) && cnt_inc == target;
      default:                               done = 1'b0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_inc;
    crc_d = crc_n;
    res_o.data_byte  = byte_i;
    res_o.byte_index = cnt_q[IdxW-1:0];
    res_o.status     = ST_RECV;
    priority if (ovf) begin
      res_o.status     = ST_OVERFLOW;
      res_o.byte_index = IdxMax;
      cnt_d = '0;
    end else if (cnt_q == '0 && byte_i != dev_addr_i && byte_i != BcastAddr) begin
      res_o.status = ST_BAD_ADDR;
      cnt_d = '0;
    end else if (cnt_q == CntW'(1) && !code_ok(byte_i)) begin
      res_o.status = ST_BAD_FUNC;
      cnt_d = '0;
    end else if (done) begin
      res_o.status = (crc_n == 16'h0000) ? ST_GOOD : ST_CRC_ERR;
      cnt_d = '0;
    end else begin
      res_o.status = ST_RECV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      fc_q  <= '0;
      len_q <= '0;
      crc_q <= CrcInit;
    end else if (step_i) begin
      if (cnt_d == '0) begin
        cnt_q <= '0;
        fc_q  <= '0;
        len_q <= '0;
        crc_q <= CrcInit;
      end else begin
        cnt_q <= cnt_d;
        fc_q  <= fc_d;
        len_q <= len_d;
        crc_q <= crc_d;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxFrame))
    else $error("frame count past limit");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> crc_q == CrcInit && fc_q == '0 && len_q == '0)
    else $error("idle state not clean");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.status != ST_RECV |=> cnt_q == '0)
    else $error("frame end did not return to idle");

  a_fc_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q > CntW'(2) |-> code_ok(fc_q))
    else $error("unsupported code held in frame");

endmodule

// ===== design/modbus_rtu_response_receiver.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU response receiver
// Result is registered and appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle unless stalled; frame state, CRC in one pass.
// Output register decouples the sides; input ready while it is empty or taken.
// Reset: address 1, quantity 0, receiver idle, CRC at 0xFFFF, no result held.
// ----------------------------------------------------------------------------
module modbus_rtu_response_receiver import mbrtu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [2:0] status, [12:3] byte_index,
                                      // [20:13] data_byte, [23:21] zero
);

  logic [7:0]  dev_addr_q;
  logic [15:0] req_qty_q;
  logic        vld_q;
  result_t     res_q, res_d;
  logic        acc;

  assign s_axis_tready = !vld_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= 8'd1;
      req_qty_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEV_ADDR: dev_addr_q <= cfg_wdata_i[7:0];
        CFG_REQ_QTY:  req_qty_q  <= cfg_wdata_i;
        default:      dev_addr_q <= dev_addr_q;
      endcase
    end
  end

  mbrtu_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (acc),
    .byte_i     (s_axis_tdata),
    .dev_addr_i (dev_addr_q),
    .req_qty_i  (req_qty_q),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (acc) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {3'b000, res_q.data_byte, res_q.byte_index, res_q.status};

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU response receiver testbench
// Streams response frames byte by byte into the receiver: short directed
// frames, a frame that overruns the maximum length, then random frames,
// broken frames and noise under several address and quantity settings.
// A frame tracker predicts status, position and byte of every result and
// checks each accepted result in order. Both stream sides pause at random.
// ----------------------------------------------------------------------------
module testbench import mbrtu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkHalf       = 5;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned PhaseBytes    = 125;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [2:0] status, [12:3] byte_index,
                               // [20:13] data_byte, [23:21] zero

  modbus_rtu_response_receiver i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ CrcPoly) : {1'b0, r[15:1]};
    return r;
  endfunction

  class rtu_frame_tracker;
    logic [7:0]      dev_addr;
    logic [15:0]     req_qty;
    logic [CntW-1:0] frame_len;
    logic [7:0]      func_code;
    logic [7:0]      len_field;
    logic [15:0]     crc_acc;
    result_t         expected_q[$];
    int unsigned     mismatches;

    function new();
      dev_addr   = 8'd1;
      req_qty    = 16'd0;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      frame_len = '0;
      func_code = 8'd0;
      len_field = 8'd0;
      crc_acc   = CrcInit;
    endfunction

    function void set_register(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CFG_DEV_ADDR: dev_addr = val[7:0];
        CFG_REQ_QTY:  req_qty  = val;
        default: ;
      endcase
    endfunction

    function bit frame_done(logic [CntW-1:0] cnt);
      logic [CntW-1:0] target;
      case (func_code)
        FcWriteCoil, FcWriteReg, FcWriteRegs: return cnt == FrameLenShort;
        FcWriteCoils: return cnt == FrameLenMulti;
        FcReadCoils, FcReadHold, FcReadInput: begin
          target = ReadHdrLen + len_field;
          if (req_qty > QtyExtLimit) target = target + ReadExtLen;
          return cnt == target;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      result_t         r;
      logic [CntW-1:0] pos;
      bit              reject;
      pos          = frame_len;
      reject       = 1'b0;
      r.data_byte  = b;
      r.byte_index = pos[IdxW-1:0];
      r.status     = ST_RECV;
      if (frame_len >= MaxFrame) begin
        r.status     = ST_OVERFLOW;
        r.byte_index = (pos > IdxMax) ? IdxMax : pos[IdxW-1:0];
        clear_frame();
      end else begin
        frame_len = frame_len + 1'b1;
        crc_acc   = crc16_step(crc_acc, b);
        if (pos == 0) begin
          if (b != dev_addr && b != BcastAddr) begin
            r.status = ST_BAD_ADDR;
            reject   = 1'b1;
          end
        end else if (pos == 1) begin
          func_code = b;
          if (!(b inside {FcReadCoils, FcReadHold, FcReadInput, FcWriteCoil,
                          FcWriteReg, FcWriteCoils, FcWriteRegs})) begin
            r.status = ST_BAD_FUNC;
            reject   = 1'b1;
          end
        end else if (pos == 2) begin
          len_field = b;
        end
        if (reject) begin
          clear_frame();
        end else if (frame_done(frame_len)) begin
          r.status = (crc_acc == 16'h0000) ? ST_GOOD : ST_CRC_ERR;
          clear_frame();
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [23:0] word);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result item 0x%06h", word);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (word[2:0] != want.status) begin
        $error("status: expected %0d, got %0d", want.status, word[2:0]);
        mismatches++;
      end
      if (word[12:3] != want.byte_index) begin
        $error("byte_index: expected %0d, got %0d", want.byte_index, word[12:3]);
        mismatches++;
      end
      if (word[20:13] != want.data_byte) begin
        $error("data_byte: expected 0x%02h, got 0x%02h", want.data_byte, word[20:13]);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  rtu_frame_tracker tracker;
  logic [7:0]       frame_buf[$];
  logic [7:0]       cur_addr;
  logic [15:0]      cur_qty;
  bit               source_steady;
  bit               sink_steady;
  int unsigned      bytes_sent;
  int unsigned      stall_left;
  int unsigned      quiet_cycles;

  always #ClkHalf clk_i = ~clk_i;

  function automatic int unsigned gap_length();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (rst_ni && !sink_steady && $urandom_range(0, 99) < 30) begin
      stall_left = gap_length();
    end
    m_axis_tready <= rst_ni && stall_left == 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) tracker.note_byte(s_axis_tdata);
      if (cfg_we_i) tracker.set_register(cfg_idx_e'(cfg_idx_i), cfg_wdata_i);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [7:0] any_code();
    case ($urandom_range(0, 6))
      0: return FcReadCoils;
      1: return FcReadHold;
      2: return FcReadInput;
      3: return FcWriteCoil;
      4: return FcWriteReg;
      5: return FcWriteCoils;
      default: return FcWriteRegs;
    endcase
  endfunction

  function automatic logic [7:0] other_code();
    logic [7:0] fc;
    do fc = 8'($urandom);
    while (fc inside {FcReadCoils, FcReadHold, FcReadInput, FcWriteCoil,
                      FcWriteReg, FcWriteCoils, FcWriteRegs});
    return fc;
  endfunction

  function automatic logic [7:0] lead_addr();
    return ($urandom_range(0, 4) == 0) ? BcastAddr : cur_addr;
  endfunction

  function automatic logic [7:0] other_addr();
    logic [7:0] a;
    do a = 8'($urandom);
    while (a == cur_addr || a == BcastAddr);
    return a;
  endfunction

  function automatic void make_frame(input logic [7:0] addr, input logic [7:0] fc,
                                     input logic [7:0] len, input bit bad_crc);
    int unsigned body;
    int unsigned pos;
    logic [15:0] acc;
    frame_buf.delete();
    frame_buf.push_back(addr);
    frame_buf.push_back(fc);
    case (fc)
      FcWriteCoils: body = 5;
      FcReadCoils, FcReadHold, FcReadInput: begin
        frame_buf.push_back(len);
        body = len + ((cur_qty > QtyExtLimit) ? ReadExtLen : 0);
      end
      default: body = 4;
    endcase
    repeat (body) frame_buf.push_back(8'($urandom));
    acc = CrcInit;
    foreach (frame_buf[i]) acc = crc16_step(acc, frame_buf[i]);
    frame_buf.push_back(acc[7:0]);
    frame_buf.push_back(acc[15:8]);
    if (bad_crc) begin
      pos = $urandom_range(3, frame_buf.size() - 1);
      frame_buf[pos] = frame_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (!source_steady && $urandom_range(0, 99) < 35) ? gap_length() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i);
    while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_buf(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(frame_buf[i]);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i);
    while (tracker.pending() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_DEV_ADDR) cur_addr = val[7:0];
    else cur_qty = val;
  endtask

  task automatic random_phase(input logic [7:0] addr, input logic [15:0] qty,
                              input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  len;
    write_reg(CFG_DEV_ADDR, {8'h00, addr});
    write_reg(CFG_REQ_QTY, qty);
    source_steady = ($urandom_range(0, 3) == 0);
    sink_steady   = ($urandom_range(0, 3) == 0);
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 19) == 0 && qty <= QtyExtLimit) ?
             8'($urandom) : 8'($urandom_range(0, 12));
      if (pick < 60) begin
        make_frame(lead_addr(), any_code(), len, $urandom_range(0, 4) == 0);
        send_buf(frame_buf.size());
      end else if (pick < 70) begin
        make_frame(other_addr(), any_code(), len, 1'b0);
        send_buf(frame_buf.size());
      end else if (pick < 80) begin
        make_frame(lead_addr(), other_code(), len, 1'b0);
        send_buf(frame_buf.size());
      end else if (pick < 90) begin
        make_frame(lead_addr(), any_code(), len, 1'b0);
        send_buf($urandom_range(1, frame_buf.size() - 1));
      end else begin
        frame_buf.delete();
        repeat ($urandom_range(1, 6)) frame_buf.push_back(8'($urandom));
        send_buf(frame_buf.size());
      end
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  initial begin
    tracker       = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DEV_ADDR;
    cfg_wdata_i   = 16'h0000;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    m_axis_tready = 1'b0;
    cur_addr      = 8'd1;
    cur_qty       = 16'd0;
    source_steady = 1'b1;
    sink_steady   = 1'b1;
    bytes_sent    = 0;
    stall_left    = 0;
    quiet_cycles  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(BcastAddr);
    send_byte(8'hFF);
    make_frame(8'h01, FcReadInput, 8'h00, 1'b0);
    send_buf(frame_buf.size());
    make_frame(BcastAddr, FcReadCoils, 8'h00, 1'b1);
    send_buf(frame_buf.size());
    make_frame(8'h01, FcWriteCoils, 8'h00, 1'b0);
    send_buf(frame_buf.size());

    // shrink the target length mid-frame so the frame runs past the maximum
    source_steady = 1'b0;
    sink_steady   = 1'b0;
    write_reg(CFG_REQ_QTY, QtyExtLimit + 16'd1);
    make_frame(cur_addr, FcReadHold, 8'h00, 1'b0);
    send_buf(3);
    repeat (97) send_byte(8'($urandom));
    write_reg(CFG_REQ_QTY, QtyExtLimit);
    repeat (MaxFrame - 100 + 1) send_byte(8'($urandom));

    random_phase(8'h01, 16'h0000, PhaseBytes);
    random_phase(BcastAddr, QtyExtLimit, PhaseBytes);
    random_phase(8'hFF, 16'hFFFF, PhaseBytes);
    random_phase(8'($urandom), 16'($urandom_range(0, 128)), PhaseBytes);
    random_phase(8'($urandom), 16'($urandom_range(129, 65535)), PhaseBytes);
    random_phase(8'($urandom), 16'($urandom_range(0, 128)), PhaseBytes);

    drain();
    repeat (4) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
